FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the analyzer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition");
`endif

FILE: rtl/core/tbpa_pkg.sv
// Package: shared types and constants of the three-band peak analyzer.
`default_nettype none
package tbpa_pkg;
    localparam int PEAK_W = 26;
    localparam int ST_W   = 40;
    localparam logic [1:0] MODE_SAMPLE  = 2'd0;
    localparam logic [1:0] MODE_READ    = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;
    localparam logic [1:0] REG_LOW_COEF  = 2'd0;
    localparam logic [1:0] REG_HIGH_COEF = 2'd1;
    localparam logic [1:0] REG_TOTAL     = 2'd2;
    localparam logic [1:0] REG_BUCKETS   = 2'd3;
    localparam logic [PEAK_W-1:0] PEAK_ONE = 26'd256;
    localparam logic [PEAK_W-1:0] PEAK_MAX = {PEAK_W{1'b1}};

    // Three band peaks travel together through the store.
    typedef struct packed {
        logic [PEAK_W-1:0] low;
        logic [PEAK_W-1:0] mid;
        logic [PEAK_W-1:0] high;
    } peaks_t;

    // Saturate a wide signed value to the 40-bit filter state range.
    function automatic logic signed [ST_W-1:0] sat40(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd549755813887;
        lo = -64'sd549755813888;
        if (v > hi) return hi[ST_W-1:0];
        if (v < lo) return lo[ST_W-1:0];
        return v[ST_W-1:0];
    endfunction

    // Magnitude with 8 fraction bits dropped, saturated to the peak width.
    function automatic logic [PEAK_W-1:0] to_peak(input logic signed [47:0] v);
        logic [47:0] m;
        m = v[47] ? 48'(-v) : 48'(v);
        m = m >> 8;
        return (m > 48'(PEAK_MAX)) ? PEAK_MAX : m[PEAK_W-1:0];
    endfunction
endpackage
`default_nettype wire

FILE: rtl/core/tbpa_div.sv
// Shared restoring divider: quotient of a numerator by a divisor, one bit a cycle.
`default_nettype none
module tbpa_div
    import tbpa_pkg::*;
#(
    parameter int NUM_W = 44,
    parameter int DEN_W = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [NUM_W-1:0]      quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);
    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next, done_reg, done_next;
    logic [DEN_W:0]   trial;

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DEN_W-1:0], quot_reg[NUM_W-1]};
        if (start) begin
            quot_next = num;
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next  = trial - {1'b0, den_reg};
                quot_next = {quot_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next  = trial;
                quot_next = {quot_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start) den_reg <= den;
    end

    assign done = done_reg;
    assign quot = quot_reg;
endmodule
`default_nettype wire

FILE: rtl/core/three_band_bucket_peak_analyzer_unit.sv
// Three-band bucket peak analyzer: filters, peak store and level scaling.
// Sample item: two filter steps, a divide for the bucket, then a read-modify-write of the store.
// Read item: result after three passes of the shared divider, one per band.
// Restart and reset: a clearing pass over every word of the peak store.
// One item is in flight; a waiting result stalls only the output step of the next read.
// Reset restores the register defaults and shared peak 1.0.
`default_nettype none
`include "assert_macros.svh"
module three_band_bucket_peak_analyzer_unit
    import tbpa_pkg::*;
#(
    parameter int MAX_BUCKETS = 2048,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [1:0]             s_mode,
    input  wire logic [SAMPLE_BITS-1:0] s_sample,
    input  wire logic [10:0]            s_read_index,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [10:0]                 m_bucket,
    output logic [7:0]                  m_low_level,
    output logic [7:0]                  m_mid_level,
    output logic [7:0]                  m_high_level,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [31:0]            cfg_data
);
    localparam int AW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int NW  = $clog2(MAX_BUCKETS + 1);
    localparam int DNW = 32 + NW;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_LOW, ST_HIGH, ST_DIVS, ST_DIVW, ST_RMW_RD, ST_RMW_WR,
        ST_RD, ST_SC_START, ST_SC_WAIT, ST_OUT
    } state_t;

    state_t state_reg;
    // configuration registers
    logic [15:0] low_coef_reg, high_coef_reg;
    logic [31:0] total_reg;
    logic [11:0] bcount_reg;
    // filter state
    logic signed [ST_W-1:0] lp_reg, hp_reg;
    logic signed [SAMPLE_BITS-1:0] prev_reg, x_reg;
    logic [31:0] cnt_reg;
    logic [PEAK_W-1:0] shared_reg;
    logic [AW-1:0] addr_reg;
    logic [1:0] band_reg;
    peaks_t rd_reg;
    logic [7:0] lvl_reg [3];
    logic [7:0] out_lvl_reg [3];
    logic [10:0] idx_reg;
    logic [10:0] out_bucket_reg;
    logic out_valid_reg;

    // peak store: one word per bucket, three bands
    peaks_t store_mem [MAX_BUCKETS];
    peaks_t mem_rdata_reg, mem_wdata;
    logic mem_we;
    logic [AW-1:0] mem_addr;

    logic [NW-1:0] nbuck;
    logic [31:0] tot;
    always_comb begin
        nbuck = (bcount_reg == 12'd0) ? NW'(1)
              : (32'(bcount_reg) > 32'(MAX_BUCKETS)) ? NW'(MAX_BUCKETS) : NW'(bcount_reg);
        tot   = (total_reg == 32'd0) ? 32'd1 : total_reg;
    end

    // filter arithmetic: two multiplies for the low stage, one for the high stage
    logic signed [63:0] xq, lo_sum, hi_in, hi_prod;
    logic signed [ST_W-1:0] mid_v;
    always_comb begin
        xq      = 64'(x_reg) <<< 16;
        lo_sum  = $signed({1'b0, low_coef_reg}) * 64'(lp_reg)
                + $signed(18'(18'h10000 - 18'(low_coef_reg))) * xq;
        hi_in   = 64'(hp_reg) + ((64'(x_reg) - 64'(prev_reg)) <<< 16);
        hi_prod = $signed({1'b0, high_coef_reg}) * hi_in;
        mid_v   = ST_W'(xq - 64'(lp_reg) - 64'(hp_reg));
    end

    // shared divider: bucket mapping and level scaling
    logic div_start, div_done;
    logic [DNW-1:0] div_num, div_quot;
    logic [31:0] div_den;
    tbpa_div #(.NUM_W(DNW), .DEN_W(32)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(div_num),
        .den(div_den), .done(div_done), .quot(div_quot)
    );

    logic [PEAK_W-1:0] band_peak;
    always_comb begin
        case (band_reg)
            2'd0:    band_peak = mem_rdata_reg.low;
            2'd1:    band_peak = rd_reg.mid;
            default: band_peak = rd_reg.high;
        endcase
        div_start = (state_reg == ST_DIVS) || (state_reg == ST_SC_START);
        if (state_reg == ST_DIVS) begin
            div_num = DNW'(cnt_reg) * DNW'(nbuck);
            div_den = tot;
        end else begin
            div_num = DNW'(band_peak) * DNW'(255);
            div_den = 32'(shared_reg);
        end
    end

    logic [AW-1:0] bkt;
    always_comb bkt = (div_quot >= DNW'(nbuck)) ? AW'(nbuck - 1'b1) : AW'(div_quot);

    logic [PEAK_W-1:0] pl, pm, ph, mx;
    always_comb begin
        pl = to_peak(48'(lp_reg));
        pm = to_peak(48'(mid_v));
        ph = to_peak(48'(hp_reg));
        mem_wdata.low  = (pl > mem_rdata_reg.low)  ? pl : mem_rdata_reg.low;
        mem_wdata.mid  = (pm > mem_rdata_reg.mid)  ? pm : mem_rdata_reg.mid;
        mem_wdata.high = (ph > mem_rdata_reg.high) ? ph : mem_rdata_reg.high;
        mx = shared_reg;
        if (pl > mx) mx = pl;
        if (pm > mx) mx = pm;
        if (ph > mx) mx = ph;
        if (state_reg == ST_CLEAR) mem_wdata = '0;
        mem_we   = (state_reg == ST_CLEAR) || (state_reg == ST_RMW_WR);
        mem_addr = addr_reg;
    end

    // memory: one port, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) store_mem[mem_addr] <= mem_wdata;
        mem_rdata_reg <= store_mem[mem_addr];
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_bucket  = out_bucket_reg;
    assign m_low_level  = out_lvl_reg[0];
    assign m_mid_level  = out_lvl_reg[1];
    assign m_high_level = out_lvl_reg[2];

    logic idx_ok;
    always_comb idx_ok = 32'(idx_reg) < 32'(nbuck);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
            low_coef_reg  <= 16'd63243;
            high_coef_reg <= 16'd37067;
            total_reg     <= 32'd1;
            bcount_reg    <= 12'd2000;
            lp_reg <= '0; hp_reg <= '0; prev_reg <= '0; cnt_reg <= '0;
            shared_reg <= PEAK_ONE;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_LOW_COEF:  low_coef_reg  <= cfg_data[15:0];
                    REG_HIGH_COEF: high_coef_reg <= cfg_data[15:0];
                    REG_TOTAL:     total_reg     <= cfg_data;
                    REG_BUCKETS:   bcount_reg    <= cfg_data[11:0];
                    default:       ;
                endcase
            end
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR: begin
                    // sweep the store, one word a cycle
                    addr_reg <= addr_reg + 1'b1;
                    if (32'(addr_reg) == 32'(MAX_BUCKETS - 1)) begin
                        addr_reg  <= '0;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        x_reg   <= s_sample;
                        idx_reg <= s_read_index;
                        if (s_mode == MODE_SAMPLE) state_reg <= ST_LOW;
                        else if (s_mode == MODE_READ) begin
                            addr_reg  <= AW'(s_read_index);
                            state_reg <= ST_RD;
                        end else if (s_mode == MODE_RESTART) begin
                            lp_reg <= '0; hp_reg <= '0; prev_reg <= '0; cnt_reg <= '0;
                            shared_reg <= PEAK_ONE;
                            addr_reg   <= '0;
                            state_reg  <= ST_CLEAR;
                        end
                    end
                end
                ST_LOW: begin
                    lp_reg    <= sat40(lo_sum >>> 16);
                    state_reg <= ST_HIGH;
                end
                ST_HIGH: begin
                    hp_reg    <= sat40(hi_prod >>> 16);
                    prev_reg  <= x_reg;
                    state_reg <= ST_DIVS;
                end
                ST_DIVS: state_reg <= ST_DIVW;
                ST_DIVW: begin
                    if (div_done) begin
                        addr_reg  <= bkt;
                        state_reg <= ST_RMW_RD;
                    end
                end
                ST_RMW_RD: state_reg <= ST_RMW_WR;
                ST_RMW_WR: begin
                    shared_reg <= mx;
                    if (cnt_reg < tot) cnt_reg <= cnt_reg + 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_RD: begin
                    // read data lands next cycle
                    band_reg  <= 2'd0;
                    state_reg <= ST_SC_START;
                end
                ST_SC_START: begin
                    if (band_reg == 2'd0) rd_reg <= mem_rdata_reg;
                    state_reg <= ST_SC_WAIT;
                end
                ST_SC_WAIT: begin
                    if (div_done) begin
                        lvl_reg[band_reg] <= idx_ok ? div_quot[7:0] : 8'd0;
                        if (band_reg == 2'd2) state_reg <= ST_OUT;
                        else begin
                            band_reg  <= band_reg + 1'b1;
                            state_reg <= ST_SC_START;
                        end
                    end
                end
                ST_OUT: begin
                    // hold the levels until the output register is free
                    if (!out_valid_reg || m_ready) begin
                        out_bucket_reg <= idx_reg;
                        out_lvl_reg    <= lvl_reg;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // band 0 scales the registered read directly; rd_reg keeps it for the later bands
    `ASSERT_IMPL(a_shared_floor, aclk, aresetn, shared_reg >= PEAK_ONE)
    `ASSERT_NEVER(a_no_accept_busy, aclk, aresetn, s_ready && state_reg != ST_IDLE)
    `ASSERT_IMPL(a_out_hold, aclk, aresetn,
        (m_valid && !m_ready) |=> (m_valid && $stable(m_bucket)))
endmodule
`default_nettype wire
